// File: rtl/core/mono_icon_blitter_scaled_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the icon blitter checker
// ----------------------------------------------------------------------------
`ifndef MONO_ICON_BLITTER_SCALED_MACROS_SVH
`define MONO_ICON_BLITTER_SCALED_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MIBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define MIBS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mibs_pkg.sv
// ----------------------------------------------------------------------------
// mibs_pkg
// shared constants and types for the one-bit icon blitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mibs_pkg;

  // default sizing
  localparam int DEF_MAX_DIM      = 64;
  localparam int DEF_BITMAP_BYTES = 512;

  // field widths
  localparam int DIM_BITS   = 7;
  localparam int SIZE_BITS  = 8;
  localparam int COORD_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;

  // divider: quotient is below icon width, so seven quotient bits
  localparam int QW = DIM_BITS;
  localparam int NW = SIZE_BITS + DIM_BITS;

  // linear bitmap address before wrap: row * row_bytes + byte column
  localparam int LW = 12;

  // leftmost pixel of a bitmap byte
  localparam logic [7:0] LEFT_PIXEL = 8'h80;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_ICON_WIDTH  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ICON_HEIGHT = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ROW_BYTES   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_DRAW_MODE   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SCALE_SIZE  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_INVERT      = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_ORIGIN_X    = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_ORIGIN_Y    = 3'd7;

  // draw modes
  localparam logic [1:0] MODE_NATIVE = 2'd0;
  localparam logic [1:0] MODE_SCALED = 2'd1;
  localparam logic [1:0] MODE_FIT    = 2'd2;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_RED,
    ST_MEM,
    ST_RDAT
  } seq_state_t;

  // sequencer controls to the datapath
  typedef struct packed {
    logic take_item;
    logic calc_pos;
    logic div_start;
    logic take_div;
    logic calc_lin;
    logic calc_quo;
    logic mem_we;
    logic out_load;
  } seq_ctrl_t;

endpackage

// File: rtl/core/mono_icon_blitter_scaled.sv
// ----------------------------------------------------------------------------
// mono_icon_blitter_scaled
// one-bit icon blitter: bitmap ram, position walk, native/scaled/fit modes
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------
//  command  | command, byte_address, byte_data          | start high, busy low
//  config   | cfg_index, cfg_data                       | cfg_we high
//  result   | draw, pixel_x, pixel_y, square_size, last | done, one cycle
//
//  load transaction: address wrap stages, then the ram write port
//  step transaction: position, bitmap address, address wrap stages and the
//    registered ram read; fit mode adds the seven-step restoring divider
//    between position and address; done rises with the result registers
//  rst is synchronous; clears position, config and control, not datapath or bitmap ram
//  the result cannot be stalled; busy covers a whole transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_icon_blitter_scaled import mibs_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int BITMAP_BYTES = DEF_BITMAP_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [8:0]                  byte_address,
  input  logic [7:0]                  byte_data,
  input  logic                        cfg_we,
  input  logic [IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data,
  output logic                        done,
  output logic                        draw,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [SIZE_BITS-1:0]        square_size,
  output logic                        last
);

  localparam int AW      = $clog2(BITMAP_BYTES);
  localparam int LRW     = (AW > LW) ? AW : LW;
  localparam int RECIP   = (1 << LW) / BITMAP_BYTES;
  localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;

  // configuration registers
  logic [DIM_BITS-1:0]   icon_width;
  logic [DIM_BITS-1:0]   icon_height;
  logic [3:0]            row_bytes;
  logic [1:0]            draw_mode;
  logic [SIZE_BITS-1:0]  scale_or_size;
  logic                  invert_bits;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;

  // effective sizes
  logic [DIM_BITS-1:0]  w_eff;
  logic [DIM_BITS-1:0]  h_eff;
  logic [SIZE_BITS-1:0] s_eff;
  logic                 fit;
  logic                 scaled;
  logic [7:0]           ext_w;
  logic [7:0]           ext_h;

  // position walk
  logic [7:0] pos_col;
  logic [7:0] pos_row;
  logic [7:0] col_n;
  logic [7:0] row_n;
  logic [7:0] col_inc;
  logic [7:0] row_inc;
  logic       col_wrap;
  logic       row_wrap;
  logic [7:0] pos_col_next;
  logic [7:0] pos_row_next;
  logic       pass_last;

  // transaction work registers
  logic                  cmd_q;
  logic [7:0]            wdata_q;
  logic [7:0]            col_q;
  logic [7:0]            row_q;
  logic                  last_q;
  logic [DIM_BITS-1:0]   sx;
  logic [DIM_BITS-1:0]   sy;
  logic [LW-1:0]         lin;
  logic [LW-1:0]         quo;
  logic [2*LW-1:0]       quo_prod;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;

  // divider
  logic [NW-1:0]   num_x;
  logic [NW-1:0]   num_y;
  logic            div_done;
  logic [QW-1:0]   qx;
  logic [QW-1:0]   qy;

  // bitmap ram
  logic [7:0]     mem [BITMAP_BYTES];
  logic [LRW-1:0] lin_ext;
  logic [LRW-1:0] qn;
  logic [LRW-1:0] r0;
  logic [LRW-1:0] r1;
  logic [AW-1:0]  mem_addr;
  logic [7:0]     rdata;
  logic           pix;

  // sequencer
  seq_state_t state;
  seq_state_t state_next;
  seq_ctrl_t  ctrl;
  logic       accept;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      icon_width    <= 7'd8;
      icon_height   <= 7'd8;
      row_bytes     <= 4'd1;
      draw_mode     <= MODE_NATIVE;
      scale_or_size <= 8'd1;
      invert_bits   <= 1'b0;
      origin_x      <= '0;
      origin_y      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ICON_WIDTH:  icon_width    <= cfg_data[DIM_BITS-1:0];
        REG_ICON_HEIGHT: icon_height   <= cfg_data[DIM_BITS-1:0];
        REG_ROW_BYTES:   row_bytes     <= cfg_data[3:0];
        REG_DRAW_MODE:   draw_mode     <= cfg_data[1:0];
        REG_SCALE_SIZE:  scale_or_size <= cfg_data[SIZE_BITS-1:0];
        REG_INVERT:      invert_bits   <= cfg_data[0];
        REG_ORIGIN_X:    origin_x      <= cfg_data;
        REG_ORIGIN_Y:    origin_y      <= cfg_data;
      endcase
    end
  end

  // clamped dimensions and pass extent
  always_comb begin
    if (icon_width == '0)
      w_eff = 7'd1;
    else if ({1'b0, icon_width} > 8'(DIM_CAP))
      w_eff = DIM_BITS'(DIM_CAP);
    else
      w_eff = icon_width;
    if (icon_height == '0)
      h_eff = 7'd1;
    else if ({1'b0, icon_height} > 8'(DIM_CAP))
      h_eff = DIM_BITS'(DIM_CAP);
    else
      h_eff = icon_height;
    s_eff  = (scale_or_size == '0) ? 8'd1 : scale_or_size;
    fit    = draw_mode == MODE_FIT;
    scaled = draw_mode == MODE_SCALED;
    ext_w  = fit ? s_eff : {1'b0, w_eff};
    ext_h  = fit ? s_eff : {1'b0, h_eff};
  end

  // next drawing position, stale counters restart at zero
  always_comb begin
    col_n        = (pos_col >= ext_w) ? 8'd0 : pos_col;
    row_n        = (pos_row >= ext_h) ? 8'd0 : pos_row;
    col_inc      = col_n + 8'd1;
    row_inc      = row_n + 8'd1;
    col_wrap     = col_inc >= ext_w;
    row_wrap     = row_inc >= ext_h;
    pos_col_next = col_wrap ? 8'd0 : col_inc;
    pos_row_next = col_wrap ? (row_wrap ? 8'd0 : row_inc) : row_n;
    pass_last    = col_wrap && row_wrap;
  end

  assign accept = start && !busy;
  assign busy   = state != ST_IDLE;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept)
          state_next = (command == CMD_LOAD) ? ST_RED : ST_MUL;
      end
      ST_MUL:  state_next = fit ? ST_DIV : ST_ADDR;
      ST_DIV:  state_next = div_done ? ST_ADDR : ST_DIV;
      ST_ADDR: state_next = ST_RED;
      ST_RED:  state_next = ST_MEM;
      ST_MEM:  state_next = (cmd_q == CMD_LOAD) ? ST_IDLE : ST_RDAT;
      ST_RDAT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer controls
  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE: ctrl.take_item = accept;
      ST_MUL: begin
        ctrl.calc_pos  = 1'b1;
        ctrl.div_start = fit;
      end
      ST_DIV:  ctrl.take_div = div_done;
      ST_ADDR: ctrl.calc_lin = 1'b1;
      ST_RED:  ctrl.calc_quo = 1'b1;
      ST_MEM:  ctrl.mem_we   = cmd_q == CMD_LOAD;
      ST_RDAT: ctrl.out_load = 1'b1;
      default: ctrl = '0;
    endcase
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_col <= '0;
      pos_row <= '0;
    end else if (ctrl.take_item && command == CMD_STEP) begin
      pos_col <= pos_col_next;
      pos_row <= pos_row_next;
    end
  end

  // fit mode source coordinates: col * w / s and row * h / s
  assign num_x = NW'(col_q) * NW'(w_eff);
  assign num_y = NW'(row_q) * NW'(h_eff);

  mibs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num_x (num_x),
    .num_y (num_y),
    .den   (s_eff),
    .done  (div_done),
    .qx    (qx),
    .qy    (qy)
  );

  // reciprocal estimate of the ram wrap quotient
  assign quo_prod = (2*LW)'(lin) * (2*LW)'(RECIP);

  // transaction datapath
  always_ff @(posedge clk) begin
    if (ctrl.take_item) begin
      cmd_q   <= command;
      wdata_q <= byte_data;
      lin     <= LW'(byte_address);
      col_q   <= col_n;
      row_q   <= row_n;
      last_q  <= pass_last;
    end
    if (ctrl.calc_pos) begin
      px <= origin_x + (scaled ? COORD_BITS'(col_q) * COORD_BITS'(s_eff)
                               : COORD_BITS'(col_q));
      py <= origin_y + (scaled ? COORD_BITS'(row_q) * COORD_BITS'(s_eff)
                               : COORD_BITS'(row_q));
      sx <= col_q[DIM_BITS-1:0];
      sy <= row_q[DIM_BITS-1:0];
    end
    if (ctrl.take_div) begin
      sx <= qx;
      sy <= qy;
    end
    if (ctrl.calc_lin)
      lin <= LW'(sy) * LW'(row_bytes) + LW'(sx[DIM_BITS-1:3]);
    if (ctrl.calc_quo)
      quo <= quo_prod[2*LW-1:LW];
  end

  // address wrap: estimate is at most one short, one correction step
  always_comb begin
    lin_ext  = LRW'(lin);
    qn       = LRW'(quo) * LRW'(BITMAP_BYTES);
    r0       = lin_ext - qn;
    r1       = ({1'b0, r0} >= (LRW+1)'(BITMAP_BYTES)) ? r0 - LRW'(BITMAP_BYTES) : r0;
    mem_addr = r1[AW-1:0];
  end

  // bitmap ram, one port, registered read
  always_ff @(posedge clk) begin
    if (ctrl.mem_we)
      mem[mem_addr] <= wdata_q;
    rdata <= mem[mem_addr];
  end

  // tested bit, msb is the leftmost pixel
  assign pix = |(rdata & (LEFT_PIXEL >> sx[2:0]));

  // result registers
  always_ff @(posedge clk) begin
    if (rst)
      done <= 1'b0;
    else
      done <= ctrl.out_load;
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      draw        <= pix ^ invert_bits;
      pixel_x     <= $signed(px);
      pixel_y     <= $signed(py);
      square_size <= scaled ? s_eff : 8'd1;
      last        <= last_q;
    end
  end

endmodule

// File: rtl/core/mibs_div.sv
// ----------------------------------------------------------------------------
// mibs_div
// dual restoring divider, one quotient bit per cycle for x and y together
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mibs_div import mibs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NW-1:0]        num_x,
  input  logic [NW-1:0]        num_y,
  input  logic [SIZE_BITS-1:0] den,
  output logic                 done,
  output logic [QW-1:0]        qx,
  output logic [QW-1:0]        qy
);

  localparam int CW = $clog2(QW);

  logic                 active;
  logic [CW-1:0]        cnt;
  logic [SIZE_BITS-1:0] rem_x;
  logic [SIZE_BITS-1:0] rem_y;
  logic [SIZE_BITS:0]   trial_x;
  logic [SIZE_BITS:0]   trial_y;
  logic                 ge_x;
  logic                 ge_y;
  logic [SIZE_BITS:0]   diff_x;
  logic [SIZE_BITS:0]   diff_y;

  // trial subtraction, dividend bits enter from the quotient register
  always_comb begin
    trial_x = {rem_x, qx[QW-1]};
    trial_y = {rem_y, qy[QW-1]};
    ge_x    = trial_x >= {1'b0, den};
    ge_y    = trial_y >= {1'b0, den};
    diff_x  = trial_x - {1'b0, den};
    diff_y  = trial_y - {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift; high dividend bits start below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_x <= num_x[NW-1:QW];
      rem_y <= num_y[NW-1:QW];
      qx    <= num_x[QW-1:0];
      qy    <= num_y[QW-1:0];
    end else if (active) begin
      rem_x <= ge_x ? diff_x[SIZE_BITS-1:0] : trial_x[SIZE_BITS-1:0];
      rem_y <= ge_y ? diff_y[SIZE_BITS-1:0] : trial_y[SIZE_BITS-1:0];
      qx    <= {qx[QW-2:0], ge_x};
      qy    <= {qy[QW-2:0], ge_y};
    end
  end

endmodule

// File: rtl/core/mibs_checker.sv
// ----------------------------------------------------------------------------
// mibs_checker
// port-level checks on the icon blitter's transaction sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_icon_blitter_scaled_macros.svh"

module mibs_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] square_size
);

  // a result strobe is never held high
  `MIBS_ASSERT(a_done_pulse, done |=> !done, "result strobe held longer than one cycle")

  // an accepted transaction keeps the block busy
  `MIBS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after accept")

  // results appear only once the transaction is finished
  `MIBS_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")

  // square edge is never zero
  `MIBS_ASSERT(a_size_nonzero, done |-> (square_size != 8'd0), "zero square size")

  // reset leaves the block idle and quiet
  `MIBS_ASSERT_RST(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind mono_icon_blitter_scaled mibs_checker u_mibs_checker (.*);

// File: dv/mono_icon_blitter_scaled_tb.sv
// ----------------------------------------------------------------------------
// mono_icon_blitter_scaled_tb
// self-checking bench for the one-bit icon blitter: bitmap loads and drawing
// steps go in through the start/busy port, and the block is set up through
// the register port between phases. A scoreboard keeps its own bitmap copy
// and position counters, predicts every draw operation, and compares each
// done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_icon_blitter_scaled_tb import mibs_pkg::*; ;

  localparam int BMP_BYTES     = DEF_BITMAP_BYTES;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int RANDOM_ITEMS  = 750;

  // the draw mode code that the block does not define
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                  draw;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  size;
    logic                  last;
  } draw_op_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         command;
  logic [8:0]                   byte_address;
  logic [7:0]                   byte_data;
  logic                         cfg_we;
  logic [IDX_BITS-1:0]          cfg_index;
  logic [CFG_BITS-1:0]          cfg_data;
  logic                         done;
  logic                         draw;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [SIZE_BITS-1:0]         square_size;
  logic                         last;

  int cycles;
  int phases;
  bit no_gaps;

  // bitmap copy, position walk and expected draw operations
  class icon_scoreboard;
    logic [7:0]            bitmap [BMP_BYTES];
    bit                    written [BMP_BYTES];
    logic [7:0]            col, row;
    logic [DIM_BITS-1:0]   width_r, height_r;
    logic [3:0]            rbytes_r;
    logic [1:0]            mode_r;
    logic [SIZE_BITS-1:0]  size_r;
    logic                  invert_r;
    logic [COORD_BITS-1:0] ox_r, oy_r;
    draw_op_t              pending [$];
    int                    errors, checked, loads, steps, passes, writes;

    function new();
      col      = '0;
      row      = '0;
      width_r  = 8;
      height_r = 8;
      rbytes_r = 1;
      mode_r   = MODE_NATIVE;
      size_r   = 1;
      invert_r = 1'b0;
      ox_r     = '0;
      oy_r     = '0;
    endfunction

    function void set_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
      writes++;
      case (idx)
        REG_ICON_WIDTH:  width_r  = value[DIM_BITS-1:0];
        REG_ICON_HEIGHT: height_r = value[DIM_BITS-1:0];
        REG_ROW_BYTES:   rbytes_r = value[3:0];
        REG_DRAW_MODE:   mode_r   = value[1:0];
        REG_SCALE_SIZE:  size_r   = value[SIZE_BITS-1:0];
        REG_INVERT:      invert_r = value[0];
        REG_ORIGIN_X:    ox_r     = value;
        REG_ORIGIN_Y:    oy_r     = value;
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize saturates
    function int unsigned dim(logic [DIM_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
      return v;
    endfunction

    function int unsigned eff_size();
      return (size_r == 0) ? 1 : size_r;
    endfunction

    // current position, restarted when a config change left it outside the pass
    function void locate(output int unsigned c, r, ew, eh);
      if (mode_r == MODE_FIT) begin
        ew = eff_size();
        eh = ew;
      end else begin
        ew = dim(width_r);
        eh = dim(height_r);
      end
      c = (col >= ew) ? 0 : col;
      r = (row >= eh) ? 0 : row;
    endfunction

    // bitmap byte and source column sampled at a position
    function void source_of(int unsigned c, r, output int unsigned addr, sx);
      int unsigned sy;
      sx = c;
      sy = r;
      if (mode_r == MODE_FIT) begin
        sx = c * dim(width_r) / eff_size();
        sy = r * dim(height_r) / eff_size();
      end
      addr = (sy * rbytes_r + (sx >> 3)) % BMP_BYTES;
    endfunction

    function int unsigned next_read_addr();
      int unsigned c, r, ew, eh, addr, sx;
      locate(c, r, ew, eh);
      source_of(c, r, addr, sx);
      return addr;
    endfunction

    function void note_item(logic cmd, logic [8:0] a, logic [7:0] d);
      int unsigned c, r, ew, eh, addr, sx, s;
      draw_op_t    op;
      if (cmd == CMD_LOAD) begin
        bitmap[a % BMP_BYTES]  = d;
        written[a % BMP_BYTES] = 1'b1;
        loads++;
        return;
      end
      locate(c, r, ew, eh);
      source_of(c, r, addr, sx);
      s = eff_size();
      op.draw = ((bitmap[addr] & (LEFT_PIXEL >> (sx % 8))) != 0) ^ invert_r;
      if (mode_r == MODE_SCALED) begin
        op.x    = ox_r + 16'(c * s);
        op.y    = oy_r + 16'(r * s);
        op.size = 8'(s);
      end else begin
        op.x    = ox_r + 16'(c);
        op.y    = oy_r + 16'(r);
        op.size = 8'd1;
      end
      // advance in row-major order, wrapping at the end of the pass
      op.last = 1'b0;
      c++;
      if (c >= ew) begin
        c = 0;
        r++;
        if (r >= eh) begin
          r = 0;
          op.last = 1'b1;
          passes++;
        end
      end
      col = c[7:0];
      row = r[7:0];
      pending.push_back(op);
      steps++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(draw_op_t got);
      draw_op_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with no step pending, x=%0d y=%0d",
                         $signed(got.x), $signed(got.y)));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.draw !== want.draw)
        report($sformatf("draw %b, want %b", got.draw, want.draw));
      if (got.x !== want.x)
        report($sformatf("pixel_x %0d, want %0d", $signed(got.x), $signed(want.x)));
      if (got.y !== want.y)
        report($sformatf("pixel_y %0d, want %0d", $signed(got.y), $signed(want.y)));
      if (got.size !== want.size)
        report($sformatf("square_size %0d, want %0d", got.size, want.size));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  icon_scoreboard sb;

  mono_icon_blitter_scaled i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .byte_address (byte_address),
    .byte_data    (byte_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .draw         (draw),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .square_size  (square_size),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("mono_icon_blitter_scaled test failed");
      $finish;
    end
  end

  // result monitor: each strobe is a one-cycle transaction
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(draw_op_t'{draw, pixel_x, pixel_y, square_size, last});
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 16'($urandom_range(1, 8));
    if (r < 14) return 16'($urandom_range(9, 64));
    if (r == 14) return 0;
    if (r == 15) return 1;
    if (r == 16) return 64;
    return 16'($urandom_range(65, 127));
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one command transaction; start stays high into the next one when no gap
  task automatic send_item(input logic cmd, input logic [8:0] addr, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    byte_address <= addr;
    byte_data    <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(cmd, addr, data);
  endtask

  // a step, preceded by a load when the byte it samples was never written
  task automatic step_item();
    int unsigned a;
    a = sb.next_read_addr();
    if (!sb.written[a]) send_item(CMD_LOAD, 9'(a), 8'($urandom));
    send_item(CMD_STEP, 9'($urandom), 8'($urandom));
  endtask

  task automatic run_steps(input int n);
    repeat (n) step_item();
  endtask

  task automatic run_traffic(input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) != 0) send_item(CMD_LOAD, 9'($urandom_range(0, 63)), 8'($urandom));
        else send_item(CMD_LOAD, 9'($urandom), 8'($urandom));
      end else begin
        step_item();
      end
    end
  endtask

  // stop issuing, drain results, let any load finish
  task automatic next_phase();
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, with junk now and then above the register's width
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
    logic [CFG_BITS-1:0] unused_bits;
    case (idx)
      REG_ICON_WIDTH, REG_ICON_HEIGHT: unused_bits = 16'hFF80;
      REG_ROW_BYTES:                   unused_bits = 16'hFFF0;
      REG_DRAW_MODE:                   unused_bits = 16'hFFFC;
      REG_SCALE_SIZE:                  unused_bits = 16'hFF00;
      REG_INVERT:                      unused_bits = 16'hFFFE;
      default:                         unused_bits = 16'h0000;
    endcase
    if ($urandom_range(0, 3) == 0) value = value | (16'($urandom) & unused_bits);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // new setting for a random phase; a subset of registers unless every_reg
  task automatic random_config(input bit every_reg);
    int  r;
    bit  mode_changed;
    logic [CFG_BITS-1:0] s;
    mode_changed = 1'b0;
    if (every_reg || $urandom_range(0, 2) == 0) write_reg(REG_ICON_WIDTH, pick_dim());
    if (every_reg || $urandom_range(0, 2) == 0) write_reg(REG_ICON_HEIGHT, pick_dim());
    if (every_reg || $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_ROW_BYTES, 16'((sb.dim(sb.width_r) + 7) / 8));
      else write_reg(REG_ROW_BYTES, 16'($urandom_range(0, 15)));
    end
    if (every_reg || $urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 9);
      mode_changed = 1'b1;
      if (r < 3) write_reg(REG_DRAW_MODE, MODE_NATIVE);
      else if (r < 6) write_reg(REG_DRAW_MODE, MODE_SCALED);
      else if (r < 9) write_reg(REG_DRAW_MODE, MODE_FIT);
      else write_reg(REG_DRAW_MODE, MODE_UNUSED);
    end
    // fit sizes are mostly small so that passes complete
    if (every_reg || mode_changed || $urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 9);
      if (sb.mode_r == MODE_FIT)
        s = (r < 7) ? 16'($urandom_range(1, 10)) : (r == 7) ? 16'd0 : (r == 8) ? 16'd255 :
            16'($urandom_range(11, 254));
      else
        s = (r == 0) ? 16'd0 : (r == 1) ? 16'd255 : 16'($urandom_range(1, 254));
      write_reg(REG_SCALE_SIZE, s);
    end
    if (every_reg || $urandom_range(0, 2) == 0) write_reg(REG_INVERT, 16'($urandom_range(0, 1)));
    if (every_reg || $urandom_range(0, 2) == 0) write_reg(REG_ORIGIN_X, pick_coord());
    if (every_reg || $urandom_range(0, 2) == 0) write_reg(REG_ORIGIN_Y, pick_coord());
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    command      = CMD_LOAD;
    byte_address = '0;
    byte_data    = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_ICON_WIDTH;
    cfg_data     = '0;
    no_gaps      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, address and data corners
    send_item(CMD_LOAD, 9'h1FF, 8'hFF);
    send_item(CMD_LOAD, 9'h000, 8'hA5);
    send_item(CMD_LOAD, 9'h001, 8'h00);
    run_steps(3);

    // narrow icon entered with the column beyond its width, one pass and a wrap
    next_phase();
    write_reg(REG_ICON_WIDTH, 2);
    write_reg(REG_ICON_HEIGHT, 2);
    run_steps(5);

    // undefined mode code draws native, inverted
    next_phase();
    write_reg(REG_DRAW_MODE, MODE_UNUSED);
    write_reg(REG_INVERT, 1);
    run_steps(2);

    // scaled: zero scale, then the largest scale at the coordinate limits
    next_phase();
    write_reg(REG_DRAW_MODE, MODE_SCALED);
    write_reg(REG_SCALE_SIZE, 0);
    run_steps(2);
    next_phase();
    write_reg(REG_SCALE_SIZE, 255);
    write_reg(REG_ORIGIN_X, 16'h7FFF);
    write_reg(REG_ORIGIN_Y, 16'h8000);
    run_steps(2);

    // fit to a single pixel: every step closes a pass
    next_phase();
    write_reg(REG_DRAW_MODE, MODE_FIT);
    write_reg(REG_SCALE_SIZE, 1);
    run_steps(2);

    // zero and oversize dimensions, long rows so the read address wraps
    next_phase();
    write_reg(REG_ICON_WIDTH, 0);
    write_reg(REG_ICON_HEIGHT, 127);
    write_reg(REG_ROW_BYTES, 15);
    write_reg(REG_SCALE_SIZE, 3);
    run_steps(9);

    // zero row bytes: every row reads the first row
    next_phase();
    write_reg(REG_ROW_BYTES, 0);
    run_steps(2);

    // random phases
    while (sb.loads + sb.steps < RANDOM_ITEMS) begin
      next_phase();
      random_config(phases == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      run_traffic($urandom_range(8, 40));
      phases++;
    end

    next_phase();
    $display("covered %0d random phases: %0d bitmap loads, %0d drawing steps, %0d reg writes",
             phases, sb.loads, sb.steps, sb.writes);
    $display("checked %0d draw operations over %0d complete passes, %0d mismatches",
             sb.checked, sb.passes, sb.errors);
    if (sb.errors == 0) $display("mono_icon_blitter_scaled test passed");
    else $display("mono_icon_blitter_scaled test failed");
    $finish;
  end

endmodule
